@@ src/first_fit_segment_allocator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit_assert.svh
// Assertion macros shared by the allocator's checker
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is held
`define FFSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffsa assertion failed");

// next-cycle implication, off while reset is held
`define FFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffsa assertion failed");

// next-cycle implication that also covers reset itself
`define FFSA_ASSERT_NEXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ffsa assertion failed");

`endif

@@ src/ffsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared constants and controller/datapath interface types of the
// first-fit segment allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;

    // default configuration
    localparam int MAX_SEGMENTS_DEF   = 16;
    localparam int POOL_ADDR_BITS_DEF = 16;

    // fixed field widths
    localparam int SIZE_W   = 17;
    localparam int OFFSET_W = 16;
    localparam int POOL_W   = 17;
    localparam int STATUS_W = 2;

    localparam logic [POOL_W-1:0] POOL_RESET = 17'h10000;

    // request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                load_req;   // capture request, clear candidate
        logic                idx_clr;    // read index to entry zero
        logic                idx_top;    // read index to entry count
        logic                idx_after;  // read index past the matching entry
        logic                rd_fwd;     // read at index, step up
        logic                rd_bwd;     // read below index, step down
        logic                walk;       // advance candidate over read segment
        logic                ins_move;   // move read segment up one slot
        logic                ins_place;  // write new segment above read slot
        logic                put0;       // write new segment at entry zero
        logic                rem_move;   // move read segment down one slot
        logic                cnt_inc;
        logic                cnt_dec;
        logic                set_stat;
        logic [STATUS_W-1:0] stat_code;
        logic                out_load;   // load the result register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_free;
        logic too_big;
        logic full;
        logic empty;
        logic fits;
        logic pv;        // read data valid
        logic last;      // read data is the last table entry
        logic above;     // read segment starts above candidate
        logic bottom;    // read data is entry zero
        logic hit;       // read segment starts at the freed offset
        logic at_end;    // read index reached the count
        logic idx_zero;
    } t_dp_stat;

endpackage

@@ src/first_fit_segment_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// First-fit allocator of segments in a byte pool, with a sorted segment table
// ----------------------------------------------------------------------------
// One transaction is handled at a time and gives exactly one result. An
// allocate walks the table through its single read port, then moves the
// entries that start above the new segment up one slot each and places the
// new segment. A free scans up to the matching entry and moves every entry
// behind it down one slot. Early rejects (size beyond the pool, full table,
// free on an empty table) skip the table. A new request is taken while the
// previous result still waits in the output register, but the next result
// is held back for as long as that result stays stalled.
module first_fit_segment_allocator_unit #(
    parameter int MAX_SEGMENTS   = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int POOL_ADDR_BITS = ffsa_pkg::POOL_ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ffsa_pkg::POOL_W-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [ffsa_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffsa_pkg::OFFSET_W-1:0] i_free_offset,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ffsa_pkg::STATUS_W-1:0] o_status,
    output logic [ffsa_pkg::OFFSET_W-1:0] o_alloc_offset
);

    ffsa_pkg::t_dp_cmd  ctl;
    ffsa_pkg::t_dp_stat sts;

    // sequencer
    ffsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctl   (ctl)
    );

    // table and arithmetic
    ffsa_datapath #(
        .MAX_SEGMENTS   (MAX_SEGMENTS),
        .POOL_ADDR_BITS (POOL_ADDR_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (i_cmd),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_status       (o_status),
        .o_alloc_offset (o_alloc_offset)
    );

endmodule

@@ src/ffsa_datapath.sv @@
// ----------------------------------------------------------------------------
// ffsa_datapath
// Segment table memory, request registers, candidate walk arithmetic and
// result register of the first-fit segment allocator
// ----------------------------------------------------------------------------
module ffsa_datapath #(
    parameter int MAX_SEGMENTS   = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int POOL_ADDR_BITS = ffsa_pkg::POOL_ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ffsa_pkg::POOL_W-1:0]   i_cfg_wr_data,
    input  logic                          i_cmd,
    input  logic [ffsa_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffsa_pkg::OFFSET_W-1:0] i_free_offset,
    input  ffsa_pkg::t_dp_cmd             i_ctl,
    output ffsa_pkg::t_dp_stat            o_sts,
    output logic [ffsa_pkg::STATUS_W-1:0] o_status,
    output logic [ffsa_pkg::OFFSET_W-1:0] o_alloc_offset
);

    // offsets and ends reach 2^POOL_ADDR_BITS
    localparam int AW   = POOL_ADDR_BITS + 1;
    localparam int CW   = ((AW > ffsa_pkg::SIZE_W) ? AW : ffsa_pkg::SIZE_W) + 1;
    localparam int EW   = 2 * AW;
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam logic [CW-1:0] SPAN = CW'(1) << POOL_ADDR_BITS;

    // table entry: {offset, end}
    logic [EW-1:0] mem [MAX_SEGMENTS];

    logic [ffsa_pkg::POOL_W-1:0]   r_pool;
    logic                          r_cmd;
    logic [ffsa_pkg::SIZE_W-1:0]   r_size;
    logic [ffsa_pkg::OFFSET_W-1:0] r_foff;
    logic [AW-1:0]                 r_cand;
    logic [CNTW-1:0]               r_count;
    logic [CNTW-1:0]               r_idx;
    logic                          r_pv;
    logic [IW-1:0]                 r_pidx;
    logic [EW-1:0]                 r_rd;
    logic [ffsa_pkg::STATUS_W-1:0] r_stat;
    logic [ffsa_pkg::STATUS_W-1:0] r_out_status;
    logic [ffsa_pkg::OFFSET_W-1:0] r_out_offset;

    logic [CW-1:0]   pool_ext;
    logic [CW-1:0]   pool_eff;
    logic [CW-1:0]   size_ext;
    logic [CW-1:0]   cand_ext;
    logic [CW-1:0]   cand_end;
    logic [CW-1:0]   rd_off_ext;
    logic [CW-1:0]   rd_end_ext;
    logic            overlap;
    logic [CNTW-1:0] idx_dn;
    logic [CNTW-1:0] pidx_ext;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic [IW-1:0]   pidx_up;
    logic [IW-1:0]   pidx_dn;
    logic [EW-1:0]   new_seg;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;

    // candidate and fit arithmetic
    assign pool_ext   = CW'(r_pool);
    assign pool_eff   = (pool_ext > SPAN) ? SPAN : pool_ext;
    assign size_ext   = CW'(r_size);
    assign cand_ext   = CW'(r_cand);
    assign cand_end   = cand_ext + size_ext;
    assign rd_off_ext = CW'(r_rd[EW-1:AW]);
    assign rd_end_ext = CW'(r_rd[AW-1:0]);
    assign overlap    = !((cand_end <= rd_off_ext) || (cand_ext >= rd_end_ext));
    assign new_seg    = {r_cand, cand_end[AW-1:0]};
    assign idx_dn     = r_idx - CNTW'(1);
    assign pidx_ext   = CNTW'(r_pidx);
    assign pidx_up    = r_pidx + IW'(1);
    assign pidx_dn    = r_pidx - IW'(1);

    // status toward the controller
    always_comb begin
        o_sts.is_free  = (r_cmd == ffsa_pkg::CMD_FREE);
        o_sts.too_big  = (size_ext > pool_eff);
        o_sts.full     = (r_count == CNTW'(MAX_SEGMENTS));
        o_sts.empty    = (r_count == '0);
        o_sts.fits     = (cand_end <= pool_eff);
        o_sts.pv       = r_pv;
        o_sts.last     = r_pv && ((pidx_ext + CNTW'(1)) == r_count);
        o_sts.above    = r_pv && (rd_off_ext > cand_ext);
        o_sts.bottom   = (r_pidx == '0);
        o_sts.hit      = r_pv && (rd_off_ext == CW'(r_foff));
        o_sts.at_end   = (r_idx == r_count);
        o_sts.idx_zero = (r_idx == '0);
    end

    // table read port, registered data
    assign rd_en   = i_ctl.rd_fwd || i_ctl.rd_bwd;
    assign rd_addr = i_ctl.rd_fwd ? r_idx[IW-1:0] : idx_dn[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd   <= mem[rd_addr];
            r_pidx <= rd_addr;
        end
    end

    // table write port: shifts and placement of the new segment
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = pidx_up;
        wr_data = r_rd;
        if (i_ctl.ins_move) begin
            wr_addr = pidx_up;
            wr_data = r_rd;
        end else if (i_ctl.ins_place) begin
            wr_addr = pidx_up;
            wr_data = new_seg;
        end else if (i_ctl.put0) begin
            wr_addr = '0;
            wr_data = new_seg;
        end else if (i_ctl.rem_move) begin
            wr_addr = pidx_dn;
            wr_data = r_rd;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // control registers: pool size, count, read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool  <= ffsa_pkg::POOL_RESET;
            r_count <= '0;
            r_idx   <= '0;
            r_pv    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pool <= i_cfg_wr_data;
            end
            if (i_ctl.cnt_inc) begin
                r_count <= r_count + CNTW'(1);
            end else if (i_ctl.cnt_dec) begin
                r_count <= r_count - CNTW'(1);
            end
            if (i_ctl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctl.idx_top) begin
                r_idx <= r_count;
            end else if (i_ctl.idx_after) begin
                r_idx <= pidx_ext + CNTW'(1);
            end else if (i_ctl.rd_fwd) begin
                r_idx <= r_idx + CNTW'(1);
            end else if (i_ctl.rd_bwd) begin
                r_idx <= idx_dn;
            end
            r_pv <= rd_en;
        end
    end

    // request, candidate and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_req) begin
            r_cmd  <= i_cmd;
            r_size <= i_req_size;
            r_foff <= i_free_offset;
            r_cand <= '0;
        end else if (i_ctl.walk && r_pv && overlap) begin
            r_cand <= r_rd[AW-1:0];
        end
        if (i_ctl.set_stat) begin
            r_stat <= i_ctl.stat_code;
        end
        if (i_ctl.out_load) begin
            r_out_status <= r_stat;
            if ((r_stat == ffsa_pkg::ST_OK) && (r_cmd == ffsa_pkg::CMD_ALLOC)) begin
                r_out_offset <= ffsa_pkg::OFFSET_W'(r_cand);
            end else begin
                r_out_offset <= '0;
            end
        end
    end

    assign o_status       = r_out_status;
    assign o_alloc_offset = r_out_offset;

endmodule

@@ src/ffsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer of the first-fit segment allocator: walks the table for an
// allocate or free transaction and hands the result to the output register
// ----------------------------------------------------------------------------
module ffsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    input  ffsa_pkg::t_dp_stat i_sts,
    output logic               o_stall,
    output logic               o_valid,
    output ffsa_pkg::t_dp_cmd  o_ctl
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_FIT    = 4'd3;
    localparam logic [3:0] S_INSERT = 4'd4;
    localparam logic [3:0] S_PUT    = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_REMOVE = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ovld;
    logic       n_ovld;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.is_free) begin
                    if (i_sts.too_big) begin
                        o_ctl.set_stat  = 1'b1;
                        o_ctl.stat_code = ffsa_pkg::ST_NO_ROOM;
                        n_state         = S_FIN;
                    end else if (i_sts.full) begin
                        o_ctl.set_stat  = 1'b1;
                        o_ctl.stat_code = ffsa_pkg::ST_FULL;
                        n_state         = S_FIN;
                    end else if (i_sts.empty) begin
                        n_state = S_FIT;
                    end else begin
                        o_ctl.idx_clr = 1'b1;
                        n_state       = S_WALK;
                    end
                end else if (i_sts.empty) begin
                    o_ctl.set_stat  = 1'b1;
                    o_ctl.stat_code = ffsa_pkg::ST_UNKNOWN;
                    n_state         = S_FIN;
                end else begin
                    o_ctl.idx_clr = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            // candidate walk over the sorted table
            S_WALK: begin
                o_ctl.walk   = 1'b1;
                o_ctl.rd_fwd = !i_sts.at_end;
                if (i_sts.last) begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (!i_sts.fits) begin
                    o_ctl.set_stat  = 1'b1;
                    o_ctl.stat_code = ffsa_pkg::ST_NO_ROOM;
                    n_state         = S_FIN;
                end else if (i_sts.empty) begin
                    o_ctl.put0      = 1'b1;
                    o_ctl.cnt_inc   = 1'b1;
                    o_ctl.set_stat  = 1'b1;
                    o_ctl.stat_code = ffsa_pkg::ST_OK;
                    n_state         = S_FIN;
                end else begin
                    o_ctl.idx_top = 1'b1;
                    n_state       = S_INSERT;
                end
            end
            // shift entries up from the top until the slot is found
            S_INSERT: begin
                o_ctl.rd_bwd = !i_sts.idx_zero;
                if (i_sts.pv) begin
                    if (i_sts.above) begin
                        o_ctl.ins_move = 1'b1;
                        if (i_sts.bottom) begin
                            n_state = S_PUT;
                        end
                    end else begin
                        o_ctl.ins_place = 1'b1;
                        o_ctl.cnt_inc   = 1'b1;
                        o_ctl.set_stat  = 1'b1;
                        o_ctl.stat_code = ffsa_pkg::ST_OK;
                        n_state         = S_FIN;
                    end
                end
            end
            S_PUT: begin
                o_ctl.put0      = 1'b1;
                o_ctl.cnt_inc   = 1'b1;
                o_ctl.set_stat  = 1'b1;
                o_ctl.stat_code = ffsa_pkg::ST_OK;
                n_state         = S_FIN;
            end
            // search for the freed offset
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_ctl.idx_after = 1'b1;
                    n_state         = S_REMOVE;
                end else begin
                    o_ctl.rd_fwd = !i_sts.at_end;
                    if (i_sts.last) begin
                        o_ctl.set_stat  = 1'b1;
                        o_ctl.stat_code = ffsa_pkg::ST_UNKNOWN;
                        n_state         = S_FIN;
                    end
                end
            end
            // close the gap by shifting later entries down
            S_REMOVE: begin
                o_ctl.rd_fwd   = !i_sts.at_end;
                o_ctl.rem_move = i_sts.pv;
                if (i_sts.at_end) begin
                    o_ctl.cnt_dec   = 1'b1;
                    o_ctl.set_stat  = 1'b1;
                    o_ctl.stat_code = ffsa_pkg::ST_OK;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovld || !i_stall) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        n_ovld = r_ovld;
        if (o_ctl.out_load) begin
            n_ovld = 1'b1;
        end else if (r_ovld && !i_stall) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovld;

endmodule

@@ src/ffsa_checker.sv @@
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks of the first-fit segment allocator, bound to the top
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_unit_assert.svh"

module ffsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [ffsa_pkg::STATUS_W-1:0] o_status,
    input logic [ffsa_pkg::OFFSET_W-1:0] o_alloc_offset
);

    // a stalled result holds
    `FFSA_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_alloc_offset))

    // a result that is not OK carries no offset
    `FFSA_ASSERT_IMPLY(a_offset_zero, i_clk, i_rst_n, o_valid && (o_status != ffsa_pkg::ST_OK), o_alloc_offset == '0)

    // an accepted transaction keeps the input side busy
    `FFSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // reset leaves no result and an open input
    `FFSA_ASSERT_NEXT_ANY(a_reset_clean, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind first_fit_segment_allocator_unit ffsa_checker u_ffsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_alloc_offset (o_alloc_offset)
);

@@ sim/first_fit_segment_allocator_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit_tb
// Self-checking bench of the first-fit segment allocator. A scoreboard keeps
// its own sorted segment table, predicts the status and offset of every
// accepted request and checks the results in order, while both sides of the
// block idle at random and the pool size is changed between bursts.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_unit_tb;

    localparam int MAX_SEG      = ffsa_pkg::MAX_SEGMENTS_DEF;
    localparam int POOL_SPAN    = 1 << ffsa_pkg::POOL_ADDR_BITS_DEF;
    localparam int HANG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 50;

    typedef struct packed {
        logic [ffsa_pkg::STATUS_W-1:0] status;
        logic [ffsa_pkg::OFFSET_W-1:0] offset;
    } t_alloc_result;

    // segment table shadow, result prediction and in-order checking
    class t_alloc_tracker;
        logic [ffsa_pkg::POOL_W-1:0]   pool_size;
        logic [ffsa_pkg::OFFSET_W-1:0] seg_off [MAX_SEG];
        logic [ffsa_pkg::SIZE_W-1:0]   seg_len [MAX_SEG];
        int                            seg_count;
        t_alloc_result                 pending_results [$];
        int                            errors;
        int                            status_hits [4];
        int                            allocs;
        int                            frees;

        function new();
            pool_size = ffsa_pkg::POOL_RESET;
            seg_count = 0;
            errors    = 0;
            allocs    = 0;
            frees     = 0;
            foreach (status_hits[k]) status_hits[k] = 0;
        endfunction

        // pool size clamped to the address span
        function int usable_pool();
            return (int'(pool_size) > POOL_SPAN) ? POOL_SPAN : int'(pool_size);
        endfunction

        // apply one accepted request to the table and queue its result
        function void note_request(logic cmd, logic [ffsa_pkg::SIZE_W-1:0] size,
                                   logic [ffsa_pkg::OFFSET_W-1:0] off);
            t_alloc_result r;
            int            cand;
            int            seg_end;
            int            pos;
            int            i;
            r.status = ffsa_pkg::ST_NO_ROOM;
            r.offset = '0;
            if (cmd == ffsa_pkg::CMD_ALLOC) begin
                allocs++;
                if (int'(size) > usable_pool()) begin
                    r.status = ffsa_pkg::ST_NO_ROOM;
                end else if (seg_count >= MAX_SEG) begin
                    r.status = ffsa_pkg::ST_FULL;
                end else begin
                    // single pass, hop to the end of every overlapped segment
                    cand = 0;
                    for (i = 0; i < seg_count; i++) begin
                        seg_end = int'(seg_off[i]) + int'(seg_len[i]);
                        if (!(cand + int'(size) <= int'(seg_off[i]) || cand >= seg_end))
                            cand = seg_end;
                    end
                    if (cand + int'(size) <= usable_pool()) begin
                        // insert after every entry at or below the candidate
                        pos = 0;
                        while (pos < seg_count && int'(seg_off[pos]) <= cand) pos++;
                        for (i = seg_count; i > pos; i--) begin
                            seg_off[i] = seg_off[i-1];
                            seg_len[i] = seg_len[i-1];
                        end
                        seg_off[pos] = cand[ffsa_pkg::OFFSET_W-1:0];
                        seg_len[pos] = size;
                        seg_count++;
                        r.status = ffsa_pkg::ST_OK;
                        r.offset = cand[ffsa_pkg::OFFSET_W-1:0];
                    end
                end
            end else begin
                frees++;
                r.status = ffsa_pkg::ST_UNKNOWN;
                // first matching entry goes, the rest shift down
                for (i = 0; i < seg_count; i++) begin
                    if (seg_off[i] == off) begin
                        for (pos = i; pos + 1 < seg_count; pos++) begin
                            seg_off[pos] = seg_off[pos+1];
                            seg_len[pos] = seg_len[pos+1];
                        end
                        seg_count--;
                        r.status = ffsa_pkg::ST_OK;
                        break;
                    end
                end
            end
            status_hits[r.status]++;
            pending_results.push_back(r);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic [ffsa_pkg::STATUS_W-1:0] status,
                                   logic [ffsa_pkg::OFFSET_W-1:0] offset);
            t_alloc_result want;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d, alloc_offset %0d",
                       status, offset);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (offset !== want.offset) begin
                $error("alloc_offset mismatch: expected %0d, actual %0d",
                       want.offset, offset);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_wr_en   = 1'b0;
    logic [ffsa_pkg::POOL_W-1:0]   i_cfg_wr_data = '0;
    logic                          i_valid       = 1'b0;
    logic                          o_stall;
    logic                          i_cmd         = ffsa_pkg::CMD_ALLOC;
    logic [ffsa_pkg::SIZE_W-1:0]   i_req_size    = '0;
    logic [ffsa_pkg::OFFSET_W-1:0] i_free_offset = '0;
    logic                          o_valid;
    logic                          i_stall       = 1'b0;
    logic [ffsa_pkg::STATUS_W-1:0] o_status;
    logic [ffsa_pkg::OFFSET_W-1:0] o_alloc_offset;

    t_alloc_tracker tracker      = new();
    bit             steady_flow  = 1'b0;
    int             quiet_cycles = 0;
    int             pool_writes  = 0;

    // clock
    always #10 i_clk = ~i_clk;

    first_fit_segment_allocator_unit #(
        .MAX_SEGMENTS   (MAX_SEG),
        .POOL_ADDR_BITS (ffsa_pkg::POOL_ADDR_BITS_DEF)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_alloc_offset (o_alloc_offset)
    );

    // result side: random stall, result check, hang counter
    always @(posedge i_clk) begin
        i_stall <= !steady_flow && ($urandom_range(99) < 8);
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_result(o_status, o_alloc_offset);
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial begin
        while (quiet_cycles < HANG_LIMIT) @(posedge i_clk);
        $error("no transaction for %0d cycles", HANG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // present one request and hold it until the block takes it
    task automatic issue_request(input logic cmd,
                                 input logic [ffsa_pkg::SIZE_W-1:0] size,
                                 input logic [ffsa_pkg::OFFSET_W-1:0] off);
        while (!steady_flow && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_req_size    <= size;
        i_free_offset <= off;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_request(cmd, size, off);
    endtask

    task automatic wait_drained();
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // new pool size, only once every result is back
    task automatic write_pool(input logic [ffsa_pkg::POOL_W-1:0] value);
        i_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.pool_size = value;
        pool_writes++;
    endtask

    // mostly frees of live segments and fitting allocates, plus noise
    task automatic run_random(input int count);
        int                            n;
        int                            roll;
        int                            room;
        int                            pick;
        logic [ffsa_pkg::SIZE_W-1:0]   size;
        logic [ffsa_pkg::OFFSET_W-1:0] off;
        for (n = 0; n < count; n++) begin
            room = tracker.usable_pool();
            size = ffsa_pkg::SIZE_W'($urandom_range(0, POOL_SPAN));
            off  = ffsa_pkg::OFFSET_W'($urandom);
            roll = $urandom_range(99);
            if (roll < 35 && tracker.seg_count > 0) begin
                pick = $urandom_range(tracker.seg_count - 1);
                issue_request(ffsa_pkg::CMD_FREE, size, tracker.seg_off[pick]);
            end else if (roll < 45) begin
                // stray offset, sometimes just past a live one
                if (tracker.seg_count > 0 && $urandom_range(1)) begin
                    pick = $urandom_range(tracker.seg_count - 1);
                    off  = ffsa_pkg::OFFSET_W'(tracker.seg_off[pick] + $urandom_range(1, 3));
                end
                issue_request(ffsa_pkg::CMD_FREE, size, off);
            end else begin
                roll = $urandom_range(99);
                if (roll < 8)
                    size = '0;
                else if (roll < 70)
                    size = ffsa_pkg::SIZE_W'($urandom_range(1, (room > 12) ? room / 12 : 1));
                else if (roll < 85)
                    size = ffsa_pkg::SIZE_W'($urandom_range(1, room));
                else if (roll < 95)
                    size = ffsa_pkg::SIZE_W'($urandom_range(0, POOL_SPAN));
                else
                    size = ffsa_pkg::SIZE_W'((roll < 98) ? room : POOL_SPAN);
                issue_request(ffsa_pkg::CMD_ALLOC, size, off);
            end
        end
    endtask

    // main sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, whole pool, zero-byte segment sharing an offset
        issue_request(ffsa_pkg::CMD_FREE, '0, '0);
        issue_request(ffsa_pkg::CMD_ALLOC, ffsa_pkg::SIZE_W'(POOL_SPAN), 16'h1234);
        issue_request(ffsa_pkg::CMD_ALLOC, '0, '0);
        issue_request(ffsa_pkg::CMD_FREE, '0, '0);
        issue_request(ffsa_pkg::CMD_FREE, '0, '0);
        // refill a hole, then walk over several segments
        issue_request(ffsa_pkg::CMD_ALLOC, 17'd100, '0);
        issue_request(ffsa_pkg::CMD_ALLOC, 17'd200, '0);
        issue_request(ffsa_pkg::CMD_ALLOC, 17'd50, '0);
        issue_request(ffsa_pkg::CMD_FREE, '0, 16'd100);
        issue_request(ffsa_pkg::CMD_ALLOC, 17'd60, '0);
        issue_request(ffsa_pkg::CMD_ALLOC, 17'd150, '0);
        issue_request(ffsa_pkg::CMD_FREE, 17'h10000, 16'hFFFF);
        // fill the table, then one more
        while (tracker.seg_count < MAX_SEG)
            issue_request(ffsa_pkg::CMD_ALLOC, 17'd1, 16'hFFFF);
        issue_request(ffsa_pkg::CMD_ALLOC, 17'd1, '0);
        // one-byte pool: size check wins over the full check
        write_pool(17'd1);
        issue_request(ffsa_pkg::CMD_ALLOC, 17'd2, '0);
        issue_request(ffsa_pkg::CMD_ALLOC, 17'd1, '0);
        issue_request(ffsa_pkg::CMD_FREE, '0, 16'd100);
        issue_request(ffsa_pkg::CMD_ALLOC, 17'd1, '0);
        issue_request(ffsa_pkg::CMD_ALLOC, '0, '0);

        // random bursts over several pool sizes
        write_pool(ffsa_pkg::POOL_RESET);
        run_random(200);
        write_pool(17'd1);
        run_random(100);
        write_pool(ffsa_pkg::POOL_W'($urandom_range(16, 1024)));
        run_random(200);
        write_pool(ffsa_pkg::POOL_W'($urandom_range(1, POOL_SPAN)));
        steady_flow = 1'b1;
        run_random(150);
        steady_flow = 1'b0;
        run_random(50);
        write_pool(17'h0FFFF);
        run_random(150);
        write_pool(ffsa_pkg::POOL_RESET);
        run_random(100);

        // drain and report
        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending_results.size() != 0) begin
            $error("%0d results never arrived", tracker.pending_results.size());
            tracker.errors++;
        end
        $display("covered %0d allocates and %0d frees over %0d pool settings",
                 tracker.allocs, tracker.frees, pool_writes + 1);
        $display("outcomes: ok %0d, no room %0d, table full %0d, unknown offset %0d",
                 tracker.status_hits[ffsa_pkg::ST_OK],
                 tracker.status_hits[ffsa_pkg::ST_NO_ROOM],
                 tracker.status_hits[ffsa_pkg::ST_FULL],
                 tracker.status_hits[ffsa_pkg::ST_UNKNOWN]);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/ffsa_pkg.sv
src/ffsa_datapath.sv
src/ffsa_ctrl.sv
src/first_fit_segment_allocator_unit.sv
src/ffsa_checker.sv
sim/first_fit_segment_allocator_unit_tb.sv
